/* hw/rtl/one_shot_timer_table_assert.svh */
// ----------------------------------------------------------------------------
// One-shot timer table assertion macros
// Concurrent checks on the table clock, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_TABLE_ASSERT_SVH
`define ONE_SHOT_TIMER_TABLE_ASSERT_SVH

// same-cycle implication
`define OTT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OTT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ott_pkg.sv */
// ----------------------------------------------------------------------------
// One-shot timer table package
// Sizes, slot and cell control types, opcodes and status codes.
// ----------------------------------------------------------------------------
package ott_pkg;

    localparam int NUM_TIMERS  = 8;
    localparam int COUNT_BITS  = 16;
    localparam int ID_BITS     = 3;
    localparam int PERIOD_BITS = 16;
    localparam int CNT_BITS    = $clog2(NUM_TIMERS + 1);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_TICK_RPT = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic [ID_BITS-1:0]    id;
        logic [COUNT_BITS-1:0] rem;
    } t_slot;

    typedef struct packed {
        logic shift;  // take the right neighbor's slot
        logic load;   // take the shared load slot (wins over shift)
    } t_cell_ctrl;

endpackage

/* hw/rtl/one_shot_timer_table.sv */
// ----------------------------------------------------------------------------
// One-shot timer table
// Ordered list of one-shot countdown timers held in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | fields
//  ---------+-----------+----------------------+------------------------------
//  command  | in        | start & !busy        | i_opcode i_timer_id i_period
//  result   | out       | o_strobe, one cycle  | o_status o_fired o_fired_id
//           |           |                      | o_last
//
// An add is answered in the cycle after its transfer; busy stays low, so adds
// may follow back to back. During a tick with N armed timers, busy is high: the
// cell row rotates once per armed timer through the head cell, then the last
// report goes out. A fired report is held until the next fire or the tick end.
// This lets last be marked. Synchronous active-low reset empties the table.
// Results cannot be stalled.
module one_shot_timer_table
    import ott_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_opcode,
    input  logic [ID_BITS-1:0]     i_timer_id,
    input  logic [PERIOD_BITS-1:0] i_period,
    output logic                   o_strobe,
    output logic [1:0]             o_status,
    output logic                   o_fired,
    output logic [ID_BITS-1:0]     o_fired_id,
    output logic                   o_last
);

    localparam int WIDE = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
    localparam logic [WIDE-1:0] CNT_MAX_W = WIDE'({COUNT_BITS{1'b1}});

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_TICK = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [CNT_BITS-1:0]   r_left, n_left;
    logic                  r_pend, n_pend;
    logic [ID_BITS-1:0]    r_pend_id, n_pend_id;

    logic                  r_strobe, n_strobe;
    logic [1:0]            r_status, n_status;
    logic                  r_fired, n_fired;
    logic [ID_BITS-1:0]    r_fired_id, n_fired_id;
    logic                  r_last, n_last;

    t_slot                 w_slot [NUM_TIMERS];
    t_slot                 w_nb   [NUM_TIMERS];
    t_cell_ctrl            w_ctrl [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] w_match;
    logic [NUM_TIMERS-1:0] w_valid;
    t_slot                 w_ld;
    logic                  w_shift;
    logic                  w_load;
    logic [CNT_BITS-1:0]   w_tail;

    logic                  w_accept;
    logic [WIDE-1:0]       w_period_w;
    logic [COUNT_BITS-1:0] w_period_sat;
    logic [COUNT_BITS-1:0] w_head_dec;
    logic                  w_head_fire;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // ------------------------------------------------------------------------
    // cell row: cell i takes cell i+1 on a shift; the end cell takes an empty
    // ------------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
            if (g == NUM_TIMERS - 1) begin : g_end
                assign w_nb[g] = '0;
            end else begin : g_mid
                assign w_nb[g] = w_slot[g+1];
            end

            assign w_ctrl[g].shift = w_shift;
            assign w_ctrl[g].load  = w_load && (CNT_BITS'(g) == w_tail);
            assign w_valid[g]      = w_slot[g].valid;

            ott_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl[g]),
                .i_nb       (w_nb[g]),
                .i_ld       (w_ld),
                .i_match_id (i_timer_id),
                .o_slot     (w_slot[g]),
                .o_match    (w_match[g])
            );
        end
    endgenerate

    // period saturates to the counter range
    always_comb begin
        w_period_w = WIDE'(i_period);
        if (w_period_w > CNT_MAX_W) begin
            w_period_sat = COUNT_BITS'(CNT_MAX_W);
        end else begin
            w_period_sat = COUNT_BITS'(w_period_w);
        end
    end

    assign w_head_dec  = w_slot[0].rem - COUNT_BITS'(1);
    assign w_head_fire = (w_head_dec == '0);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_left     = r_left;
        n_pend     = r_pend;
        n_pend_id  = r_pend_id;
        n_strobe   = 1'b0;
        n_status   = ST_ADDED;
        n_fired    = 1'b0;
        n_fired_id = '0;
        n_last     = 1'b0;
        w_shift    = 1'b0;
        w_load     = 1'b0;
        w_tail     = r_cnt;
        w_ld       = '{valid: 1'b1, id: i_timer_id, rem: w_period_sat};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_ADD) begin
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                        if (|w_match) begin
                            n_status = ST_DUP;
                        end else if (i_period == '0) begin
                            n_status = ST_ZERO;
                        end else if (r_cnt == CNT_BITS'(NUM_TIMERS)) begin
                            n_status = ST_DUP;
                        end else begin
                            n_status = ST_ADDED;
                            w_load   = 1'b1;
                            n_cnt    = r_cnt + CNT_BITS'(1);
                        end
                    end else begin
                        n_state = S_TICK;
                        n_left  = r_cnt;
                        n_pend  = 1'b0;
                    end
                end
            end
            S_TICK: begin
                if (r_left != '0) begin
                    // pop the head, requeue it at the tail unless it expired
                    w_shift = 1'b1;
                    w_tail  = r_cnt - CNT_BITS'(1);
                    w_ld    = '{valid: 1'b1, id: w_slot[0].id, rem: w_head_dec};
                    n_left  = r_left - CNT_BITS'(1);
                    if (w_head_fire) begin
                        n_cnt     = r_cnt - CNT_BITS'(1);
                        n_pend    = 1'b1;
                        n_pend_id = w_slot[0].id;
                        if (r_pend) begin
                            n_strobe   = 1'b1;
                            n_status   = ST_TICK_RPT;
                            n_fired    = 1'b1;
                            n_fired_id = r_pend_id;
                        end
                    end else begin
                        w_load = 1'b1;
                    end
                end else begin
                    n_state    = S_IDLE;
                    n_strobe   = 1'b1;
                    n_status   = ST_TICK_RPT;
                    n_last     = 1'b1;
                    n_fired    = r_pend;
                    n_fired_id = r_pend ? r_pend_id : '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_left   <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_left   <= n_left;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_id  <= n_pend_id;
        r_status   <= n_status;
        r_fired    <= n_fired;
        r_fired_id <= n_fired_id;
        r_last     <= n_last;
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_fired    = r_fired;
    assign o_fired_id = r_fired_id;
    assign o_last     = r_last;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
`include "one_shot_timer_table_assert.svh"

    `OTT_ASSERT_NOW(a_cnt_matches_valid, 1'b1, $countones(w_valid) == r_cnt, "count mismatch")
    `OTT_ASSERT_NEXT(a_add_reply, w_accept && (i_opcode == OP_ADD), o_strobe && o_last && (o_status != ST_TICK_RPT), "add reply missing")
    `OTT_ASSERT_NOW(a_tick_end_idle, o_strobe && o_last && (o_status == ST_TICK_RPT), !busy, "tick end while busy")
    `OTT_ASSERT_NOW(a_quiet_is_last, o_strobe && (o_status == ST_TICK_RPT) && !o_fired, o_last && (o_fired_id == '0), "quiet report not last")

endmodule

/* hw/rtl/ott_cell.sv */
// ----------------------------------------------------------------------------
// One-shot timer table cell
// Holds one timer slot; shifts from its right neighbor or loads a new slot.
// ----------------------------------------------------------------------------
module ott_cell
    import ott_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  t_slot              i_nb,
    input  t_slot              i_ld,
    input  logic [ID_BITS-1:0] i_match_id,
    output t_slot              o_slot,
    output logic               o_match
);

    logic                  r_valid;
    logic [ID_BITS-1:0]    r_id;
    logic [COUNT_BITS-1:0] r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= i_ld.valid;
        end else if (i_ctrl.shift) begin
            r_valid <= i_nb.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_id  <= i_ld.id;
            r_rem <= i_ld.rem;
        end else if (i_ctrl.shift) begin
            r_id  <= i_nb.id;
            r_rem <= i_nb.rem;
        end
    end

    assign o_slot  = '{valid: r_valid, id: r_id, rem: r_rem};
    assign o_match = r_valid && (r_id == i_match_id);

endmodule
